### design/textured_rect_clip_macros.svh
`ifndef TEXTURED_RECT_CLIP_MACROS_SVH
`define TEXTURED_RECT_CLIP_MACROS_SVH

// same-cycle implication, consequent may carry a fixed delay
`define TRC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("textured_rect_clip assertion failed");

// next-cycle implication
`define TRC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("textured_rect_clip assertion failed");

`endif

### design/trc_pkg.sv
package trc_pkg;

  localparam int NLANE     = 4;
  localparam int QBITS     = 17;
  // stage A, B, C, divider steps
  localparam int NSTG      = QBITS + 3;
  localparam int LATENCY   = NSTG + 1;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM = CFG_IDX_W'(3);

  localparam logic signed [15:0] CLIP_LEFT_RST   = 16'sd0;
  localparam logic signed [15:0] CLIP_TOP_RST    = 16'sd0;
  localparam logic signed [15:0] CLIP_RIGHT_RST  = 16'sd32767;
  localparam logic signed [15:0] CLIP_BOTTOM_RST = 16'sd32767;

  typedef struct packed {
    logic               vis;
    logic               enclosed;
    logic signed [15:0] l;
    logic signed [15:0] t;
    logic signed [15:0] r;
    logic signed [15:0] b;
    logic [31:0]        rgba;
    logic [NLANE-1:0][15:0] tex;
  } side_t;

  typedef struct packed {
    logic signed [16:0] off;
    logic signed [16:0] span;
    logic signed [16:0] dt;
    logic [15:0]        ts;
  } lane_a_t;

  typedef struct packed {
    logic signed [33:0] prod;
    logic signed [16:0] span;
    logic [15:0]        ts;
  } lane_b_t;

  typedef struct packed {
    logic [31:0]       rem;
    logic [15:0]       den;
    logic [QBITS-1:0]  q;
    logic              neg;
    logic              zero;
    logic              sat;
    logic [15:0]       ts;
  } div_t;

endpackage

### design/textured_rect_clip.sv
// textured_rect_clip: clips a textured screen rectangle against a bounds rectangle.
// Input: drive the rectangle on in_* and pulse start; a word is taken at any
// edge with start high and busy low. busy is never raised, so one word can be
// taken every cycle.
// Output: out_valid is high for one cycle with the clipped corners, the
// re-interpolated texture coordinates and the color. The receiver cannot
// stall; results leave in the order the words came in.
// Pipeline: the input compare stage, the multiply stage, the magnitude stage,
// a 17 stage restoring divider (one quotient bit per stage, four lanes side by
// side) and the output register.
// Throughput: one word per cycle; every stage takes a new word each cycle.
// Bounds registers: cfg_valid/cfg_ready with cfg_index and cfg_wdata; ready
// is always high. Indexes above 3 are dropped. Bounds are sampled when a word
// enters, so write them only while the pipeline is empty.
// Reset: synchronous, active low; clears the pipeline valid bits and loads the
// default bounds (0, 0, 32767, 32767). No clearing pass is needed.
module textured_rect_clip
  import trc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [15:0]   in_scr_left,
  input  logic signed [15:0]   in_scr_top,
  input  logic signed [15:0]   in_scr_right,
  input  logic signed [15:0]   in_scr_bottom,
  input  logic [15:0]          in_tex_u_start,
  input  logic [15:0]          in_tex_v_start,
  input  logic [15:0]          in_tex_u_end,
  input  logic [15:0]          in_tex_v_end,
  input  logic [31:0]          in_rgba,
  output logic                 out_valid,
  output logic                 out_visible,
  output logic signed [15:0]   out_left,
  output logic signed [15:0]   out_top,
  output logic signed [15:0]   out_right,
  output logic signed [15:0]   out_bottom,
  output logic [15:0]          out_u_start,
  output logic [15:0]          out_v_start,
  output logic [15:0]          out_u_end,
  output logic [15:0]          out_v_end,
  output logic [31:0]          out_rgba,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_wdata
);

  logic signed [15:0] clip_left_r, clip_top_r, clip_right_r, clip_bottom_r;

  logic [NSTG-1:0] vl_r;
  side_t           sd_r [NSTG];
  lane_a_t         a_r  [NLANE];
  lane_b_t         b_r  [NLANE];
  div_t            dv_r [QBITS+1][NLANE];

  side_t           side_nxt;
  lane_a_t         a_nxt [NLANE];
  logic            take;

  logic            out_valid_r, out_visible_r;
  logic signed [15:0] out_left_r, out_top_r, out_right_r, out_bottom_r;
  logic [NLANE-1:0][15:0] out_tex_r, tex_nxt;
  logic [31:0]     out_rgba_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign take      = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_left_r   <= CLIP_LEFT_RST;
      clip_top_r    <= CLIP_TOP_RST;
      clip_right_r  <= CLIP_RIGHT_RST;
      clip_bottom_r <= CLIP_BOTTOM_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CLIP_LEFT:   clip_left_r   <= cfg_wdata;
        REG_CLIP_TOP:    clip_top_r    <= cfg_wdata;
        REG_CLIP_RIGHT:  clip_right_r  <= cfg_wdata;
        REG_CLIP_BOTTOM: clip_bottom_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage A: bounds tests, corner clamp, offsets and spans
  always_comb begin
    logic signed [15:0] p  [NLANE];
    logic signed [15:0] s0 [NLANE];
    logic signed [15:0] s1 [NLANE];
    logic [15:0]        te [NLANE];
    side_nxt.vis = !(in_scr_left > clip_right_r || in_scr_right < clip_left_r ||
                     in_scr_top > clip_bottom_r || in_scr_bottom < clip_top_r);
    side_nxt.enclosed = in_scr_left >= clip_left_r && in_scr_right <= clip_right_r &&
                        in_scr_top >= clip_top_r && in_scr_bottom <= clip_bottom_r;
    side_nxt.l = (in_scr_left > clip_left_r) ? in_scr_left : clip_left_r;
    side_nxt.t = (in_scr_top > clip_top_r) ? in_scr_top : clip_top_r;
    side_nxt.r = (in_scr_right < clip_right_r) ? in_scr_right : clip_right_r;
    side_nxt.b = (in_scr_bottom < clip_bottom_r) ? in_scr_bottom : clip_bottom_r;
    side_nxt.rgba = in_rgba;
    side_nxt.tex[0] = in_tex_u_start;
    side_nxt.tex[1] = in_tex_v_start;
    side_nxt.tex[2] = in_tex_u_end;
    side_nxt.tex[3] = in_tex_v_end;
    p[0] = side_nxt.l; s0[0] = in_scr_left; s1[0] = in_scr_right;
    p[1] = side_nxt.t; s0[1] = in_scr_top;  s1[1] = in_scr_bottom;
    p[2] = side_nxt.r; s0[2] = in_scr_left; s1[2] = in_scr_right;
    p[3] = side_nxt.b; s0[3] = in_scr_top;  s1[3] = in_scr_bottom;
    te[0] = in_tex_u_end; te[1] = in_tex_v_end;
    te[2] = in_tex_u_end; te[3] = in_tex_v_end;
    for (int i = 0; i < NLANE; i++) begin
      a_nxt[i].off  = {p[i][15], p[i]} - {s0[i][15], s0[i]};
      a_nxt[i].span = {s1[i][15], s1[i]} - {s0[i][15], s0[i]};
      a_nxt[i].ts   = (i == 0 || i == 2) ? in_tex_u_start : in_tex_v_start;
      a_nxt[i].dt   = $signed({1'b0, te[i]}) - $signed({1'b0, a_nxt[i].ts});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vl_r <= '0;
    end else begin
      vl_r <= {vl_r[NSTG-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    sd_r[0] <= side_nxt;
    for (int s = 1; s < NSTG; s++) begin
      sd_r[s] <= sd_r[s-1];
    end
  end

  // stages A, B, C
  always_ff @(posedge clk) begin
    logic signed [33:0] pm;
    logic signed [16:0] sm;
    for (int i = 0; i < NLANE; i++) begin
      a_r[i] <= a_nxt[i];
      b_r[i].prod <= a_r[i].off * a_r[i].dt;
      b_r[i].span <= a_r[i].span;
      b_r[i].ts   <= a_r[i].ts;
      pm = b_r[i].prod[33] ? -b_r[i].prod : b_r[i].prod;
      sm = b_r[i].span[16] ? -b_r[i].span : b_r[i].span;
      dv_r[0][i].rem  <= pm[31:0];
      dv_r[0][i].den  <= sm[15:0];
      dv_r[0][i].q    <= '0;
      dv_r[0][i].neg  <= b_r[i].prod[33] ^ b_r[i].span[16];
      dv_r[0][i].zero <= (b_r[i].span == '0);
      dv_r[0][i].sat  <= {1'b0, pm[31:0]} >= {sm[15:0], 17'b0};
      dv_r[0][i].ts   <= b_r[i].ts;
    end
  end

  function automatic div_t div_step(div_t d, int k);
    logic [32:0] sh;
    div_t        o;
    o  = d;
    sh = 33'(d.den) << k;
    if ({1'b0, d.rem} >= sh) begin
      o.rem  = d.rem - sh[31:0];
      o.q[k] = 1'b1;
    end
    return o;
  endfunction

  // restoring divider, one quotient bit per stage, MSB first
  for (genvar j = 0; j < QBITS; j++) begin : g_div
    always_ff @(posedge clk) begin
      for (int i = 0; i < NLANE; i++) begin
        dv_r[j+1][i] <= div_step(dv_r[j][i], QBITS - 1 - j);
      end
    end
  end

  // final: add start coordinate, clamp, select
  always_comb begin
    logic signed [18:0] sum;
    div_t               d;
    for (int i = 0; i < NLANE; i++) begin
      d   = dv_r[QBITS][i];
      sum = d.neg ? $signed({3'b0, d.ts}) - $signed({2'b0, d.q})
                  : $signed({3'b0, d.ts}) + $signed({2'b0, d.q});
      priority if (sd_r[NSTG-1].enclosed) begin
        tex_nxt[i] = sd_r[NSTG-1].tex[i];
      end else if (d.zero) begin
        tex_nxt[i] = d.ts;
      end else if (d.sat) begin
        tex_nxt[i] = d.neg ? 16'h0000 : 16'hFFFF;
      end else if (sum < 0) begin
        tex_nxt[i] = 16'h0000;
      end else if (sum > 19'sd65535) begin
        tex_nxt[i] = 16'hFFFF;
      end else begin
        tex_nxt[i] = sum[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vl_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (sd_r[NSTG-1].vis) begin
      out_visible_r <= 1'b1;
      out_left_r    <= sd_r[NSTG-1].l;
      out_top_r     <= sd_r[NSTG-1].t;
      out_right_r   <= sd_r[NSTG-1].r;
      out_bottom_r  <= sd_r[NSTG-1].b;
      out_tex_r     <= tex_nxt;
      out_rgba_r    <= sd_r[NSTG-1].rgba;
    end else begin
      out_visible_r <= 1'b0;
      out_left_r    <= '0;
      out_top_r     <= '0;
      out_right_r   <= '0;
      out_bottom_r  <= '0;
      out_tex_r     <= '0;
      out_rgba_r    <= '0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_visible = out_visible_r;
  assign out_left    = out_left_r;
  assign out_top     = out_top_r;
  assign out_right   = out_right_r;
  assign out_bottom  = out_bottom_r;
  assign out_u_start = out_tex_r[0];
  assign out_v_start = out_tex_r[1];
  assign out_u_end   = out_tex_r[2];
  assign out_v_end   = out_tex_r[3];
  assign out_rgba    = out_rgba_r;

`include "textured_rect_clip_macros.svh"

  `TRC_ASSERT_NOW(a_latency, start && !busy, ##LATENCY out_valid)
  `TRC_ASSERT_NXT(a_hidden_zero, vl_r[NSTG-1] && !sd_r[NSTG-1].vis,
                  out_valid && out_rgba == '0 && out_u_start == '0 && out_left == '0)
  `TRC_ASSERT_NOW(a_div_rem, vl_r[NSTG-1] && !dv_r[QBITS][0].zero && !dv_r[QBITS][0].sat,
                  {16'b0, dv_r[QBITS][0].den} > dv_r[QBITS][0].rem)

endmodule

### tb/tb.sv
module tb;
  import trc_pkg::*;

  typedef struct packed {
    logic               vis;
    logic signed [15:0] l;
    logic signed [15:0] t;
    logic signed [15:0] r;
    logic signed [15:0] b;
    logic [15:0]        us;
    logic [15:0]        vs;
    logic [15:0]        ue;
    logic [15:0]        ve;
    logic [31:0]        rgba;
  } quad_t;

  typedef struct packed {
    logic signed [15:0] l;
    logic signed [15:0] t;
    logic signed [15:0] r;
    logic signed [15:0] b;
    logic [15:0]        us;
    logic [15:0]        vs;
    logic [15:0]        ue;
    logic [15:0]        ve;
    logic [31:0]        rgba;
  } rect_t;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic signed [15:0] in_scr_left = '0, in_scr_top = '0, in_scr_right = '0, in_scr_bottom = '0;
  logic [15:0] in_tex_u_start = '0, in_tex_v_start = '0, in_tex_u_end = '0, in_tex_v_end = '0;
  logic [31:0] in_rgba = '0;
  logic out_valid, out_visible;
  logic signed [15:0] out_left, out_top, out_right, out_bottom;
  logic [15:0] out_u_start, out_v_start, out_u_end, out_v_end;
  logic [31:0] out_rgba;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  textured_rect_clip dut (.*);

  initial forever #5 clk = ~clk;

  int signed bnd_l = int'(CLIP_LEFT_RST), bnd_t = int'(CLIP_TOP_RST);
  int signed bnd_r = int'(CLIP_RIGHT_RST), bnd_b = int'(CLIP_BOTTOM_RST);
  quad_t clipped_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit gaps_on = 1;

  task automatic report(string what, int unsigned got, int unsigned want);
    errors++;
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
  endtask

  function automatic logic [15:0] lerp_tex(int signed p, int signed s0, int signed s1,
                                           logic [15:0] t0, logic [15:0] t1);
    longint signed span, r;
    span = longint'(s1) - s0;
    if (span == 0) return t0;
    r = longint'(t0) + ((longint'(p) - s0) * (longint'(t1) - longint'(t0))) / span;
    if (r < 0) r = 0;
    if (r > 65535) r = 65535;
    return r[15:0];
  endfunction

  function automatic quad_t clip_rect(rect_t x);
    quad_t q;
    int signed sl, st, sr, sb, l, t, r, b;
    q = '0;
    sl = int'(x.l); st = int'(x.t); sr = int'(x.r); sb = int'(x.b);
    if (sl > bnd_r || sr < bnd_l || st > bnd_b || sb < bnd_t) return q;
    q.vis = 1;
    q.rgba = x.rgba;
    if (sl >= bnd_l && sr <= bnd_r && st >= bnd_t && sb <= bnd_b) begin
      l = sl; t = st; r = sr; b = sb;
      q.us = x.us; q.vs = x.vs; q.ue = x.ue; q.ve = x.ve;
    end else begin
      l = sl > bnd_l ? sl : bnd_l;
      t = st > bnd_t ? st : bnd_t;
      r = sr < bnd_r ? sr : bnd_r;
      b = sb < bnd_b ? sb : bnd_b;
      q.us = lerp_tex(l, sl, sr, x.us, x.ue);
      q.vs = lerp_tex(t, st, sb, x.vs, x.ve);
      q.ue = lerp_tex(r, sl, sr, x.us, x.ue);
      q.ve = lerp_tex(b, st, sb, x.vs, x.ve);
    end
    q.l = 16'(l); q.t = 16'(t); q.r = 16'(r); q.b = 16'(b);
    return q;
  endfunction

  function automatic rect_t mk_rect(int l, int t, int r, int b, int us, int vs,
                                    int ue, int ve, logic [31:0] rgba);
    rect_t x;
    x.l = 16'(l); x.t = 16'(t); x.r = 16'(r); x.b = 16'(b);
    x.us = 16'(us); x.vs = 16'(vs); x.ue = 16'(ue); x.ve = 16'(ve);
    x.rgba = rgba;
    return x;
  endfunction

  task automatic send_rect(rect_t x);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    start <= 1;
    in_scr_left <= x.l; in_scr_top <= x.t; in_scr_right <= x.r; in_scr_bottom <= x.b;
    in_tex_u_start <= x.us; in_tex_v_start <= x.vs;
    in_tex_u_end <= x.ue; in_tex_v_end <= x.ve;
    in_rgba <= x.rgba;
    do @(posedge clk); while (busy);
    clipped_q = {clipped_q, clip_rect(x)};
  endtask

  task automatic drain();
    start <= 0;
    while (clipped_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_bound(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      REG_CLIP_LEFT:   bnd_l = int'($signed(val));
      REG_CLIP_TOP:    bnd_t = int'($signed(val));
      REG_CLIP_RIGHT:  bnd_r = int'($signed(val));
      REG_CLIP_BOTTOM: bnd_b = int'($signed(val));
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_bounds(int signed l, int signed t, int signed r, int signed b);
    write_bound(REG_CLIP_LEFT, l[15:0]);
    write_bound(REG_CLIP_TOP, t[15:0]);
    write_bound(REG_CLIP_RIGHT, r[15:0]);
    write_bound(REG_CLIP_BOTTOM, b[15:0]);
  endtask

  function automatic rect_t rand_rect();
    rect_t x;
    x = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return x;
  endfunction

  // corners near the bounds so most words get clipped
  function automatic rect_t near_rect();
    rect_t x;
    int signed a, c;
    x = rand_rect();
    a = bnd_l + $signed($urandom_range(0, 800)) - 400;
    c = a + $signed($urandom_range(0, 1200)) - 100;
    x.l = 16'(a); x.r = 16'(c);
    a = bnd_t + $signed($urandom_range(0, 800)) - 400;
    c = a + $signed($urandom_range(0, 1200)) - 100;
    x.t = 16'(a); x.b = 16'(c);
    if ($urandom_range(0, 5) == 0) x.r = x.l;
    if ($urandom_range(0, 5) == 0) x.b = x.t;
    return x;
  endfunction

  task automatic test_directed();
    rect_t x;
    set_bounds(-100, -50, 200, 300);
    x = mk_rect(-200, -100, 100, 400, 0, 16'hffff, 16'hffff, 0, 32'hdeadbeef);
    send_rect(x);
    x = mk_rect(0, 0, 100, 100, 16'h1234, 16'h5678, 16'h9abc, 16'hdef0, 32'h01020304);
    send_rect(x);
    x = mk_rect(200, 300, 400, 500, 1, 2, 3, 4, 32'hffffffff);
    send_rect(x);
    x = mk_rect(-300, -300, -100, -50, 5, 6, 7, 8, 32'h5);
    send_rect(x);
    x = mk_rect(201, 0, 400, 10, 1, 1, 1, 1, 32'h7);
    send_rect(x);
    x = mk_rect(0, -60, 10, -51, 1, 1, 1, 1, 32'h7);
    send_rect(x);
    x = mk_rect(-32768, -32768, 32767, 32767, 0, 0, 16'hffff, 16'hffff, 32'h80000001);
    send_rect(x);
    x = mk_rect(-150, 0, -150, 0, 100, 200, 300, 400, 32'h9);
    send_rect(x);
    x = mk_rect(150, 250, -150, -100, 16'hffff, 0, 0, 16'hffff, 32'ha);
    send_rect(x);
    x = mk_rect(-200, -200, 50, 50, 65535, 65535, 65535, 65535, 32'hb);
    send_rect(x);
    drain();
    set_bounds(300, 300, -300, -300);
    x = mk_rect(-400, -400, 400, 400, 0, 0, 65535, 65535, 32'hc);
    send_rect(x);
    x = mk_rect(0, 0, 0, 0, 10, 20, 30, 40, 32'hd);
    send_rect(x);
    drain();
    write_bound(8'd4, 16'h1111);
    write_bound(8'hff, 16'h2222);
    set_bounds(-32768, -32768, 32767, 32767);
    repeat (4) send_rect(rand_rect());
    x = mk_rect(-32768, 32767, 32767, -32768, 0, 65535, 65535, 0, 32'he);
    send_rect(x);
    drain();
  endtask

  task automatic test_random();
    int signed a, c;
    for (int p = 0; p < 8; p++) begin
      a = $signed($urandom_range(0, 4000)) - 2000;
      c = $signed($urandom_range(0, 4000)) - 2000;
      if (p == 0) set_bounds(CLIP_LEFT_RST, CLIP_TOP_RST, CLIP_RIGHT_RST, CLIP_BOTTOM_RST);
      else if (p == 7) set_bounds(32767, 32767, -32768, -32768);
      else set_bounds(a, c, a + $urandom_range(0, 3000), c + $urandom_range(0, 3000));
      if (p == 6) gaps_on = 0;
      for (int i = 0; i < 100; i++)
        send_rect($urandom_range(0, 4) == 0 ? rand_rect() : near_rect());
      drain();
    end
  endtask

  always @(posedge clk) begin
    quad_t w;
    if (rst_n && out_valid) begin
      if (clipped_q.size() == 0) report("unexpected word", 0, 0);
      else begin
        w = clipped_q.pop_front();
        if (out_visible !== w.vis) report("visible", out_visible, w.vis);
        if (out_left !== w.l) report("left", out_left, w.l);
        if (out_top !== w.t) report("top", out_top, w.t);
        if (out_right !== w.r) report("right", out_right, w.r);
        if (out_bottom !== w.b) report("bottom", out_bottom, w.b);
        if (out_u_start !== w.us) report("u_start", out_u_start, w.us);
        if (out_v_start !== w.vs) report("v_start", out_v_start, w.vs);
        if (out_u_end !== w.ue) report("u_end", out_u_end, w.ue);
        if (out_v_end !== w.ve) report("v_end", out_v_end, w.ve);
        if (out_rgba !== w.rgba) report("rgba", out_rgba, w.rgba);
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_random();
    if (clipped_q.size() != 0) report("words left over", clipped_q.size(), 0);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
